// File: rtl/cartesian_polar_converter_assert.svh
// Assertion macros for the converter RTL, included by cpc_post.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define CPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpc check failed");

// Next-cycle implication.
`define CPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpc check failed");

`endif

// File: rtl/cpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// Types, constants and the arctangent table of the CORDIC coordinate converter.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int ITERATIONS = 16;
  localparam int SHW        = $clog2(ITERATIONS);
  localparam int XW         = 34;
  localparam int ZW         = 34;
  localparam int ZPW        = 35;
  localparam int ATW        = 30;
  localparam int OUT_W      = 40;

  localparam logic signed [ZW-1:0]  PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZPW-1:0] PI_Q30_W    = 35'sd3373259426;
  localparam logic signed [ZPW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [31:0]    GAIN_Q30    = 32'sd652032874;

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_RECT  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  origin;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } vec_t;

  // Coordinate in Q7.8 scaled up by 2^14.
  function automatic logic signed [XW-1:0] coord_ext(input logic signed [15:0] v);
    return {{(XW-30){v[15]}}, v, 14'b0};
  endfunction

  function automatic logic [SHW-1:0] shift_of(input int k);
    return k[SHW-1:0];
  endfunction

  // atan(2^-i) in Q0.30, rounded to nearest.
  function automatic logic [ATW-1:0] atan_q30(input int i);
    logic [ATW-1:0] r;
    case (i)
      0:       r = 30'd843314857;
      1:       r = 30'd497837829;
      2:       r = 30'd263043837;
      3:       r = 30'd133525159;
      4:       r = 30'd67021687;
      5:       r = 30'd33543516;
      6:       r = 30'd16775851;
      7:       r = 30'd8388437;
      8:       r = 30'd4194283;
      9:       r = 30'd2097149;
      10:      r = 30'd1048576;
      11:      r = 30'd524288;
      12:      r = 30'd262144;
      13:      r = 30'd131072;
      14:      r = 30'd65536;
      15:      r = 30'd32768;
      16:      r = 30'd16384;
      17:      r = 30'd8192;
      18:      r = 30'd4096;
      19:      r = 30'd2048;
      20:      r = 30'd1024;
      21:      r = 30'd512;
      22:      r = 30'd256;
      23:      r = 30'd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/cartesian_polar_converter.sv
`timescale 1ns / 1ps
// Pipeline from request to result: 2 setup stages, one per CORDIC iteration,
// 16 here, then multiply and output stages.
// Throughput: one request per cycle; each stage holds when the one after it
// is full and stalled, so a waiting result stalls only the stages behind it.
// Reset (rst, synchronous) empties every stage; no data is cleared.
// ----------------------------------------------------------------------------
// cartesian_polar_converter
// Pipelined CORDIC conversion between rectangular and polar coordinates.
// ----------------------------------------------------------------------------
module cartesian_polar_converter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,  // coord_a[15:0], coord_b[31:16]
  input  logic                         s_tuser,  // operation[0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cpc_pkg::OUT_W-1:0]    m_tdata   // result_a[16:0], result_b[32:17]
);

  localparam int N = cpc_pkg::ITERATIONS;

  cpc_pkg::vec_t       vec   [N+1];
  logic [N:0]          vld;
  logic [N:0]          rdy;
  logic signed [16:0]  result_a;
  logic signed [15:0]  result_b;

  cpc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s_tvalid),
    .up_ready (s_tready),
    .op_in    (cpc_pkg::op_t'(s_tuser)),
    .a_in     (s_tdata[15:0]),
    .b_in     (s_tdata[31:16]),
    .valid    (vld[0]),
    .dn_ready (rdy[0]),
    .dn       (vec[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    cpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (cpc_pkg::shift_of(k)),
      .atan     (cpc_pkg::atan_q30(k)),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up       (vec[k]),
      .valid    (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn       (vec[k+1])
    );
  end

  cpc_post u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vld[N]),
    .up_ready (rdy[N]),
    .up       (vec[N]),
    .valid    (m_tvalid),
    .dn_ready (m_tready),
    .result_a (result_a),
    .result_b (result_b)
  );

  assign m_tdata = {{(cpc_pkg::OUT_W-33){1'b0}}, result_b, result_a};

endmodule

// File: rtl/cpc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_prep
// Two-stage front end: wraps the input angle, then folds the vector or the angle
// into the right half plane and sets up the starting vector for the rotation cells.
// ----------------------------------------------------------------------------
module cpc_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  cpc_pkg::op_t        op_in,
  input  logic signed [15:0]  a_in,
  input  logic signed [15:0]  b_in,
  output logic                valid,
  input  logic                dn_ready,
  output cpc_pkg::vec_t       dn
);

  logic                               s1_valid;
  logic                               s1_ready;
  cpc_pkg::op_t                       s1_op;
  logic signed [15:0]                 s1_a;
  logic signed [15:0]                 s1_b;
  logic signed [cpc_pkg::ZW-1:0]      s1_z;
  logic signed [cpc_pkg::ZPW-1:0]     z_raw;
  logic signed [cpc_pkg::ZPW-1:0]     z_wrap;
  logic signed [cpc_pkg::XW-1:0]      xs;
  logic signed [cpc_pkg::XW-1:0]      ys;
  cpc_pkg::vec_t                      dn_next;

  assign s1_ready = !s1_valid || dn_ready;
  assign up_ready = s1_ready;

  // Bring the angle into -pi..pi; one turn is always enough for a Q3.12 input.
  always_comb begin
    z_raw = {b_in[15], b_in, 18'b0};
    if (z_raw > cpc_pkg::PI_Q30_W) begin
      z_wrap = z_raw - cpc_pkg::TWO_PI_Q30;
    end else if (z_raw < -cpc_pkg::PI_Q30_W) begin
      z_wrap = z_raw + cpc_pkg::TWO_PI_Q30;
    end else begin
      z_wrap = z_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up_valid;
    end
    if (s1_ready && up_valid) begin
      s1_op <= op_in;
      s1_a  <= a_in;
      s1_b  <= b_in;
      s1_z  <= z_wrap[cpc_pkg::ZW-1:0];
    end
  end

  always_comb begin
    xs = cpc_pkg::coord_ext(s1_a);
    ys = cpc_pkg::coord_ext(s1_b);
    dn_next.op     = s1_op;
    dn_next.origin = 1'b0;
    dn_next.x      = xs;
    dn_next.y      = ys;
    dn_next.z      = '0;
    case (s1_op)
      cpc_pkg::OP_TO_POLAR: begin
        dn_next.origin = (s1_a == 16'sd0) && (s1_b == 16'sd0);
        // Left half plane: turn by pi first.
        if (s1_a < 16'sd0) begin
          dn_next.x = -xs;
          dn_next.y = -ys;
          dn_next.z = (s1_b < 16'sd0) ? -cpc_pkg::PI_Q30 : cpc_pkg::PI_Q30;
        end
      end
      cpc_pkg::OP_TO_RECT: begin
        dn_next.y = '0;
        dn_next.z = s1_z;
        // Fold into -pi/2..pi/2 and mirror the radius.
        if (s1_z > cpc_pkg::HALF_PI_Q30) begin
          dn_next.z = s1_z - cpc_pkg::PI_Q30;
          dn_next.x = -xs;
        end else if (s1_z < -cpc_pkg::HALF_PI_Q30) begin
          dn_next.z = s1_z + cpc_pkg::PI_Q30;
          dn_next.x = -xs;
        end
      end
      default: begin
        dn_next.origin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (dn_ready) begin
      valid <= s1_valid;
    end
    if (dn_ready && s1_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// File: rtl/cpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_cell
// One CORDIC micro-rotation stage: shift-add on x and y, table step on z.
// ----------------------------------------------------------------------------
module cpc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cpc_pkg::SHW-1:0]     shift,
  input  logic [cpc_pkg::ATW-1:0]     atan,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  cpc_pkg::vec_t               up,
  output logic                        valid,
  input  logic                        dn_ready,
  output cpc_pkg::vec_t               dn
);

  logic signed [cpc_pkg::XW-1:0] xi;
  logic signed [cpc_pkg::XW-1:0] yi;
  logic signed [cpc_pkg::ZW-1:0] zi;
  logic signed [cpc_pkg::XW-1:0] dx;
  logic signed [cpc_pkg::XW-1:0] dy;
  logic signed [cpc_pkg::ZW-1:0] da;
  logic                          neg;
  cpc_pkg::vec_t                 dn_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    xi  = up.x;
    yi  = up.y;
    zi  = up.z;
    dx  = yi >>> shift;
    dy  = xi >>> shift;
    da  = {{(cpc_pkg::ZW-cpc_pkg::ATW){1'b0}}, atan};
    // Vectoring steers on y, rotation steers on z.
    neg = (up.op == cpc_pkg::OP_TO_RECT) ? zi[cpc_pkg::ZW-1] : !yi[cpc_pkg::XW-1];
    dn_next = up;
    if (neg) begin
      dn_next.x = xi + dx;
      dn_next.y = yi - dy;
      dn_next.z = zi + da;
    end else begin
      dn_next.x = xi - dx;
      dn_next.y = yi + dy;
      dn_next.z = zi - da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// File: rtl/cpc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_post
// Back end: gain removal by multiply, then rounding, clamping and the output
// register.
// ----------------------------------------------------------------------------
module cpc_post (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  cpc_pkg::vec_t        up,
  output logic                 valid,
  input  logic                 dn_ready,
  output logic signed [16:0]   result_a,
  output logic signed [15:0]   result_b
);

  `include "cartesian_polar_converter_assert.svh"

  logic                           m_valid;
  logic                           m_ready;
  logic                           o_ready;
  cpc_pkg::op_t                   m_op;
  logic                           m_origin;
  logic signed [63:0]             px;
  logic signed [63:0]             py;
  logic signed [cpc_pkg::ZW-1:0]  mz;
  logic signed [31:0]             x32;
  logic signed [31:0]             y32;
  logic signed [63:0]             px_rnd;
  logic signed [63:0]             py_rnd;
  logic signed [cpc_pkg::ZW-1:0]  z_rnd;
  logic signed [19:0]             rx;
  logic signed [19:0]             ry;
  logic signed [15:0]             rz;
  logic signed [16:0]             result_a_next;
  logic signed [15:0]             result_b_next;
  cpc_pkg::op_t                   out_op;

  assign o_ready  = !valid || dn_ready;
  assign m_ready  = !m_valid || o_ready;
  assign up_ready = m_ready;

  assign x32 = up.x[31:0];
  assign y32 = up.y[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= up_valid;
    end
    if (m_ready && up_valid) begin
      m_op     <= up.op;
      m_origin <= up.origin;
      px       <= x32 * cpc_pkg::GAIN_Q30;
      py       <= y32 * cpc_pkg::GAIN_Q30;
      mz       <= up.z;
    end
  end

  always_comb begin
    // Round to nearest, ties up: add half, keep the upper bits.
    px_rnd = px + 64'sh0000_0800_0000_0000;
    py_rnd = py + 64'sh0000_0800_0000_0000;
    z_rnd  = mz + 34'sd131072;
    rx     = px_rnd[63:44];
    ry     = py_rnd[63:44];
    rz     = z_rnd[cpc_pkg::ZW-1:18];
    result_a_next = '0;
    result_b_next = '0;
    case (m_op)
      cpc_pkg::OP_TO_POLAR: begin
        if (rx < 20'sd0) begin
          result_a_next = '0;
        end else if (rx > 20'sd46341) begin
          result_a_next = 17'sd46341;
        end else begin
          result_a_next = rx[16:0];
        end
        if (rz > 16'sd12868) begin
          result_b_next = 16'sd12868;
        end else if (rz < -16'sd12868) begin
          result_b_next = -16'sd12868;
        end else begin
          result_b_next = rz;
        end
        if (m_origin) begin
          result_a_next = '0;
          result_b_next = '0;
        end
      end
      cpc_pkg::OP_TO_RECT: begin
        if (rx > 20'sd32767) begin
          result_a_next = 17'sd32767;
        end else if (rx < -20'sd32768) begin
          result_a_next = -17'sd32768;
        end else begin
          result_a_next = rx[16:0];
        end
        if (ry > 20'sd32767) begin
          result_b_next = 16'sd32767;
        end else if (ry < -20'sd32768) begin
          result_b_next = -16'sd32768;
        end else begin
          result_b_next = ry[15:0];
        end
      end
      default: begin
        result_a_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (o_ready) begin
      valid <= m_valid;
    end
    if (o_ready && m_valid) begin
      result_a <= result_a_next;
      result_b <= result_b_next;
      out_op   <= m_op;
    end
  end

  `CPC_ASSERT_IMP(a_polar_range, valid && out_op == cpc_pkg::OP_TO_POLAR,
    !result_a[16] && result_b <= 16'sd12868 && result_b >= -16'sd12868)
  `CPC_ASSERT_IMP(a_rect_range, valid && out_op == cpc_pkg::OP_TO_RECT,
    result_a[16] == result_a[15])
  `CPC_ASSERT_NXT(a_mult_drains, m_valid && o_ready, valid)
  `CPC_ASSERT_IMP(a_reset_empty, $past(rst), !valid && !m_valid)

endmodule
